### hw/rtl/fdp_pkg.sv
// package for the fp32 dot product: binary32 constants and pipeline types
package fdp_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_ZERO  = 32'h0000_0000;
  localparam logic [7:0]  EXP_MAX   = 8'hFF;

  typedef logic signed [10:0] exp_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [31:0] prod;
  } prod_stage_t;

endpackage

### hw/rtl/fp32_dot_product.sv
// fp32 dot product: streamed multiply, separately rounded accumulate, sum on last
//
// in_elem_a / in_elem_b carry one binary32 element pair per transfer; in_last
// marks the final pair of a vector. One pair may be transferred every cycle while in_stall is low.
// Each pair goes through two stages: the multiply stage rounds a*b to binary32
// into the product register, the accumulate stage adds it to the running sum,
// rounding to nearest even. The running-sum loop closes in the accumulate
// stage alone, so throughput is one pair per cycle unless in_stall is raised.
// On a pair with in_last set, the accumulate stage registers out_dot_sum and
// raises out_valid once the output is free, and the running sum returns to +0 for the next vector.
// Every NaN comes out as 0x7FC00000.
// Reset clears the running sum to +0 and empties both stages and the output.
// While out_stall holds a result, pairs without the last mark keep flowing;
// a second pair with the last mark waits in the product register, and only then is
// in_stall raised.
module fp32_dot_product
  import fdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_elem_a,
  input  logic [31:0] in_elem_b,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_dot_sum
);

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // value = m * 2^(e - 174), rounded to binary32 nearest even
  function automatic logic [31:0] round_pack(input logic s, input exp_t e,
                                             input logic [47:0] m);
    logic [5:0]  lz;
    exp_t        ex;
    exp_t        rs;
    logic [47:0] n;
    logic        st;
    logic        up;
    logic [30:0] res;
    lz = lzc48(m);
    st = 1'b0;
    if (e - exp_t'(1) >= exp_t'({5'd0, lz})) begin
      n  = m << lz;
      ex = e - exp_t'({5'd0, lz});
    end else if (e >= exp_t'(1)) begin
      n  = m << (e - exp_t'(1));
      ex = '0;
    end else begin
      rs = exp_t'(1) - e;
      if (rs > exp_t'(48)) rs = exp_t'(48);
      n  = m >> rs;
      st = ((n << rs) != m);
      ex = '0;
    end
    up  = n[23] & (st | (|n[22:0]) | n[24]);
    res = {ex[7:0], n[46:24]} + 31'(up);
    if (ex >= exp_t'(255)) res = {EXP_MAX, 23'd0};
    return {s, res};
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == EXP_MAX) && (x[22:0] != '0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == EXP_MAX) && (x[22:0] == '0);
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [23:0] ma;
    logic [23:0] mb;
    exp_t        e;
    logic [31:0] r;
    s  = a[31] ^ b[31];
    ma = {(a[30:23] != '0), a[22:0]};
    mb = {(b[30:23] != '0), b[22:0]};
    e  = exp_t'({3'd0, (a[30:23] == '0) ? 8'd1 : a[30:23]})
       + exp_t'({3'd0, (b[30:23] == '0) ? 8'd1 : b[30:23]}) - exp_t'(126);
    if (is_nan(a) || is_nan(b) ||
        (is_inf(a) && b[30:0] == '0) || (is_inf(b) && a[30:0] == '0)) begin
      r = CANON_NAN;
    end else if (is_inf(a) || is_inf(b)) begin
      r = {s, EXP_MAX, 23'd0};
    end else if (a[30:0] == '0 || b[30:0] == '0) begin
      // a zero factor gives a signed zero whatever the other exponent
      r = {s, 31'd0};
    end else begin
      r = round_pack(s, e, ma * mb);
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [47:0] mx;
    logic [47:0] my;
    logic [47:0] ya;
    logic [47:0] m;
    logic [31:0] r;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex = (x[30:23] == '0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == '0) ? 8'd1 : y[30:23];
    d  = ex - ey;
    if (d > 8'd48) d = 8'd48;
    mx = {1'b0, (x[30:23] != '0), x[22:0], 23'd0};
    my = {1'b0, (y[30:23] != '0), y[22:0], 23'd0};
    ya = my >> d;
    ya[0] = ya[0] | ((ya << d) != my);
    m  = (x[31] == y[31]) ? mx + ya : mx - ya;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31])) begin
      r = CANON_NAN;
    end else if (is_inf(x)) begin
      r = x;
    end else if (m == '0) begin
      r = {x[31] & y[31], 31'd0};
    end else begin
      r = round_pack(x[31], exp_t'({3'd0, ex}) + exp_t'(1), m);
    end
    return r;
  endfunction

  prod_stage_t p_r;
  prod_stage_t p_nxt;
  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [31:0] sum;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_sum_r;
  logic        out_free;
  logic        add_go;
  logic        p_free;

  assign out_free = !out_valid_r || !out_stall;
  assign add_go   = p_r.valid && (!p_r.last || out_free);
  assign p_free   = !p_r.valid || add_go;
  assign in_stall = !p_free;
  assign sum      = fp_add(acc_r, p_r.prod);

  always_comb begin
    p_nxt = p_r;
    if (p_free) begin
      p_nxt.valid = in_valid;
      p_nxt.last  = in_last;
      p_nxt.prod  = fp_mul(in_elem_a, in_elem_b);
    end
    acc_nxt = acc_r;
    if (add_go) acc_nxt = p_r.last ? POS_ZERO : sum;
    out_valid_nxt = out_valid_r && out_stall;
    if (add_go && p_r.last) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r.valid   <= 1'b0;
      p_r.last    <= 1'b0;
      acc_r       <= POS_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      p_r.valid   <= p_nxt.valid;
      p_r.last    <= p_nxt.last;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r.prod <= p_nxt.prod;
    if (add_go && p_r.last) out_sum_r <= sum;
  end

  assign out_valid   = out_valid_r;
  assign out_dot_sum = out_sum_r;

  // a full input side only ever comes from a finished sum blocked at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (p_r.valid && p_r.last && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // the accumulator restarts from +0 after every finished vector
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (add_go && p_r.last) |=> (acc_r == POS_ZERO && out_valid_r))
    else $error("accumulator not cleared after last transfer");

  a_reset_zero: assert property (@(posedge clk)
    !rst_n |=> (acc_r == POS_ZERO && !out_valid_r && !p_r.valid))
    else $error("state not cleared by reset");

endmodule
